// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pkg
// Types and protocol constants of the telnet receive-stream parser.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam logic [7:0] OPT_ECHO = 8'd1;
	localparam logic [7:0] OPT_EOR  = 8'd25;
	localparam logic [7:0] CMD_GA   = 8'd249;
	localparam logic [7:0] CMD_WILL = 8'd251;
	localparam logic [7:0] CMD_WONT = 8'd252;
	localparam logic [7:0] CMD_DO   = 8'd253;
	localparam logic [7:0] CMD_DONT = 8'd254;
	localparam logic [7:0] CMD_IAC  = 8'd255;
	localparam logic [7:0] CHR_CR   = 8'd13;
	localparam logic [7:0] CHR_LF   = 8'd10;
	localparam logic [7:0] CHR_NUL  = 8'd0;

	localparam logic [2:0] VERB_NONE = 3'd0;
	localparam logic [2:0] VERB_WILL = 3'd1;
	localparam logic [2:0] VERB_WONT = 3'd2;
	localparam logic [2:0] VERB_DO   = 3'd3;
	localparam logic [2:0] VERB_DONT = 3'd4;

	localparam logic [1:0] DLV_NONE   = 2'd0;
	localparam logic [1:0] DLV_LINE   = 2'd1;
	localparam logic [1:0] DLV_PROMPT = 2'd2;
	localparam logic [1:0] DLV_FLUSH  = 2'd3;

	localparam int OUT_W = 32;

	typedef struct packed {
		logic       iac_seen;
		logic [2:0] pending_verb;
		logic       echo_flag;
		logic       eor_flag;
	} state_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic [1:0] deliver;
		logic       send_reply;
		logic [7:0] reply_verb;
		logic [7:0] reply_option;
		logic       echo_changed;
		logic       echo_flag_out;
		logic       eor_flag_out;
	} result_t;

endpackage : tsp_pkg
`default_nettype wire

// ===== rtl/tsp_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_decode
// Byte decoder: next parser state and the result for one received byte.
// ----------------------------------------------------------------------------
module tsp_decode (
	input  wire logic [7:0]       in_byte,
	input  wire logic             raw_mode,
	input  wire tsp_pkg::state_t  cur,
	output tsp_pkg::state_t       nxt,
	output tsp_pkg::result_t      res
);
	import tsp_pkg::*;

	logic verb_pending;
	logic is_verb;

	assign verb_pending = (cur.pending_verb >= VERB_WILL) && (cur.pending_verb <= VERB_DONT);
	assign is_verb      = (in_byte >= CMD_WILL) && (in_byte <= CMD_DONT);

	always_comb begin
		nxt = cur;
		res = '0;
		if (in_byte == CHR_NUL) begin
			// Chunk end is honored even in the middle of a command sequence.
			if (raw_mode) begin
				res.deliver = DLV_FLUSH;
			end
		end else if (!cur.iac_seen) begin
			if (in_byte == CMD_IAC) begin
				nxt.iac_seen = 1'b1;
			end else if (in_byte == CHR_CR && !raw_mode) begin
				res.deliver = DLV_NONE;
			end else if (in_byte == CHR_LF && !raw_mode) begin
				res.deliver = DLV_LINE;
			end else begin
				res.data_valid = 1'b1;
				res.data_byte  = in_byte;
			end
		end else if (!verb_pending) begin
			if (is_verb) begin
				nxt.pending_verb = in_byte[2:0] - CMD_WILL[2:0] + VERB_WILL;
			end else if (in_byte == CMD_GA || (in_byte == OPT_EOR && cur.eor_flag)) begin
				res.deliver  = DLV_PROMPT;
				nxt.iac_seen = 1'b0;
			end else begin
				nxt.iac_seen = 1'b0;
			end
		end else begin
			nxt.iac_seen     = 1'b0;
			nxt.pending_verb = VERB_NONE;
			if (in_byte == OPT_ECHO) begin
				if (cur.pending_verb == VERB_DO) begin
					res.send_reply   = 1'b1;
					res.reply_verb   = CMD_WONT;
					res.reply_option = OPT_ECHO;
				end else if (cur.pending_verb == VERB_WILL || cur.pending_verb == VERB_WONT) begin
					// Remote WONT ECHO turns local echo on.
					if (cur.echo_flag != (cur.pending_verb == VERB_WONT)) begin
						nxt.echo_flag    = (cur.pending_verb == VERB_WONT);
						res.send_reply   = 1'b1;
						res.reply_verb   = (cur.pending_verb == VERB_WONT) ? CMD_DONT : CMD_DO;
						res.reply_option = OPT_ECHO;
						res.echo_changed = 1'b1;
					end
				end
			end else if (in_byte == OPT_EOR) begin
				if (cur.pending_verb == VERB_DO) begin
					res.send_reply   = 1'b1;
					res.reply_verb   = CMD_WONT;
					res.reply_option = OPT_EOR;
				end else if (cur.pending_verb == VERB_WILL || cur.pending_verb == VERB_WONT) begin
					if (cur.eor_flag != (cur.pending_verb == VERB_WILL)) begin
						nxt.eor_flag     = (cur.pending_verb == VERB_WILL);
						res.send_reply   = 1'b1;
						res.reply_verb   = (cur.pending_verb == VERB_WILL) ? CMD_DO : CMD_DONT;
						res.reply_option = OPT_EOR;
					end
				end
			end else begin
				if (cur.pending_verb == VERB_DO) begin
					res.send_reply   = 1'b1;
					res.reply_verb   = CMD_WONT;
					res.reply_option = in_byte;
				end else if (cur.pending_verb == VERB_WILL) begin
					res.send_reply   = 1'b1;
					res.reply_verb   = CMD_DONT;
					res.reply_option = in_byte;
				end
			end
		end
		res.echo_flag_out = nxt.echo_flag;
		res.eor_flag_out  = nxt.eor_flag;
	end

endmodule : tsp_decode
`default_nettype wire

// ===== rtl/telnet_stream_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// telnet_stream_parser
// Telnet receive-stream parser with IAC option negotiation.
//
// Received bytes enter on the s_axis channel, one byte per beat. Every byte
// yields exactly one result beat on m_axis: line data, a line, prompt or
// chunk delivery code, an optional negotiation reply and the echo and EOR
// flags. The raw_mode register is written through cfg_we and cfg_wdata.
// A byte is captured in an input register, decoded against the parser state
// and lands in the result register that drives m_axis; one byte is taken in
// every cycle while the receiver keeps m_axis_tready high.
// The state registers update when a byte moves into the result register.
// When the receiver stalls, the result register holds and one more byte can
// wait in the input register; s_axis_tready then drops until m_axis moves.
// Reset clears the parser state, the raw_mode register and both valid flags.
// ----------------------------------------------------------------------------
module telnet_stream_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] data_valid, [8:1] data_byte, [10:9] deliver, [11] send_reply,
	// [19:12] reply_verb, [27:20] reply_option, [28] echo_changed,
	// [29] echo_flag_out, [30] eor_flag_out, [31] zero
	output logic [tsp_pkg::OUT_W-1:0] m_axis_tdata
);
	import tsp_pkg::*;

	logic       raw_mode_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       out_valid_q;
	logic       advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	tsp_decode u_decode (
		.in_byte  (byte_s1),
		.raw_mode (raw_mode_q),
		.cur      (state_q),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q  <= 1'b0;
			valid_s1    <= 1'b0;
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				raw_mode_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, res_q.eor_flag_out, res_q.echo_flag_out, res_q.echo_changed,
		res_q.reply_option, res_q.reply_verb, res_q.send_reply, res_q.deliver,
		res_q.data_byte, res_q.data_valid};

	// A reply always carries one of the four negotiation verbs.
	a_reply_verb: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.send_reply) |->
		(res_q.reply_verb >= CMD_WILL && res_q.reply_verb <= CMD_DONT))
		else $error("reply with a verb outside WILL..DONT");

	// A data beat carries no delivery and no reply.
	a_data_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.data_valid) |->
		(res_q.deliver == DLV_NONE && !res_q.send_reply))
		else $error("data byte combined with delivery or reply");

	// A pending verb only exists inside an IAC sequence.
	a_verb_in_iac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.pending_verb != VERB_NONE) |-> state_q.iac_seen)
		else $error("pending verb outside IAC sequence");

	// The flags shown in the result track the parser state.
	a_flags_track: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_q.echo_flag_out == state_q.echo_flag &&
			res_q.eor_flag_out == state_q.eor_flag))
		else $error("result flags differ from parser state");

	// A stalled result beat is not overwritten.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !advance)
		else $error("result register overwritten under stall");

endmodule : telnet_stream_parser
`default_nettype wire

// ===== tb/sv/tb_telnet_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_telnet_stream_parser
// Self-checking bench for the telnet receive-stream parser.
//
// Bytes go in on the s_axis side. Each accepted byte is run through a
// behavioral copy of the parser state (IAC tracking, pending verb, echo and
// EOR flags, raw mode), and the expected result beat is queued. Every m_axis
// beat is compared field by field with the oldest queued result. A short
// table of hand-picked sequences runs first. Random phases follow, each with
// its own raw_mode setting and its own rate of idle and stall cycles.
// ----------------------------------------------------------------------------
module tb_telnet_stream_parser;
	import tsp_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int WD_LIMIT    = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_BYTES = 240;
	localparam bit ROW_BYTE    = 1'b0;
	localparam bit ROW_CFG     = 1'b1;

	typedef struct {
		bit         kind;
		logic [7:0] val;
		bit         chk;
		logic [1:0] dlv;
		logic       rep;
		logic [7:0] verb;
		logic [7:0] opt;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic                    cfg_wdata;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [7:0]              s_axis_tdata;   // [7:0] in_byte
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	// [0] data_valid, [8:1] data_byte, [10:9] deliver, [11] send_reply,
	// [19:12] reply_verb, [27:20] reply_option, [28] echo_changed,
	// [29] echo_flag_out, [30] eor_flag_out, [31] zero
	logic [OUT_W-1:0]        m_axis_tdata;

	// Parser state as the bench expects it to be.
	logic       raw_mode_q = 1'b0;
	logic       iac_q      = 1'b0;
	logic [2:0] verb_q     = VERB_NONE;
	logic       echo_q     = 1'b0;
	logic       eor_q      = 1'b0;

	result_t    rx_results_q [$];
	logic [7:0] stim_q [$];
	stim_row_t  dir_rows [$];
	int         mismatches   = 0;
	int         idle_cycles  = 0;
	int         tx_gap_pct   = 0;
	int         rx_stall_pct = 0;
	int         hold_seq     = 0;
	int         hold_done    = 0;
	int         stall_left   = 0;
	result_t    got_r;
	result_t    want_r;

	telnet_stream_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// Advances the parser state by one received byte and returns the beat
	// that the byte should produce.
	function automatic result_t decode_rx_byte(input logic [7:0] c);
		result_t    r;
		logic       mode;
		r = '0;
		if (c == CHR_NUL) begin
			// A zero byte only ends a chunk, and only in raw mode; any IAC sequence state survives it.
			if (raw_mode_q)
				r.deliver = DLV_FLUSH;
		end else if (!iac_q) begin
			if (c == CMD_IAC) begin
				iac_q = 1'b1;
			end else if (c == CHR_LF && !raw_mode_q) begin
				r.deliver = DLV_LINE;
			end else if (c != CHR_CR || raw_mode_q) begin
				r.data_valid = 1'b1;
				r.data_byte  = c;
			end
		end else if (verb_q < VERB_WILL || verb_q > VERB_DONT) begin
			if (c >= CMD_WILL && c <= CMD_DONT) begin
				verb_q = 3'(c - CMD_WILL) + VERB_WILL;
			end else if (c == CMD_GA || (c == OPT_EOR && eor_q)) begin
				r.deliver = DLV_PROMPT;
				iac_q     = 1'b0;
			end else begin
				iac_q = 1'b0;
			end
		end else begin
			if (c == OPT_ECHO) begin
				if (verb_q == VERB_DO) begin
					r.send_reply = 1'b1;
					r.reply_verb = CMD_WONT;
				end else if (verb_q == VERB_WILL || verb_q == VERB_WONT) begin
					mode = (verb_q == VERB_WONT);
					if (echo_q != mode) begin
						echo_q         = mode;
						r.send_reply   = 1'b1;
						r.reply_verb   = mode ? CMD_DONT : CMD_DO;
						r.echo_changed = 1'b1;
					end
				end
			end else if (c == OPT_EOR) begin
				if (verb_q == VERB_DO) begin
					r.send_reply = 1'b1;
					r.reply_verb = CMD_WONT;
				end else if (verb_q == VERB_WILL || verb_q == VERB_WONT) begin
					mode = (verb_q == VERB_WILL);
					if (eor_q != mode) begin
						eor_q        = mode;
						r.send_reply = 1'b1;
						r.reply_verb = mode ? CMD_DO : CMD_DONT;
					end
				end
			end else if (verb_q == VERB_DO) begin
				r.send_reply = 1'b1;
				r.reply_verb = CMD_WONT;
			end else if (verb_q == VERB_WILL) begin
				r.send_reply = 1'b1;
				r.reply_verb = CMD_DONT;
			end
			if (r.send_reply)
				r.reply_option = c;
			iac_q  = 1'b0;
			verb_q = VERB_NONE;
		end
		r.echo_flag_out = echo_q;
		r.eor_flag_out  = eor_q;
		return r;
	endfunction

	function automatic stim_row_t mk_row(input bit kind, input logic [7:0] val,
			input bit chk, input logic [1:0] dlv, input logic [7:0] verb,
			input logic [7:0] opt);
		stim_row_t row;
		row.kind = kind;
		row.val  = val;
		row.chk  = chk;
		row.dlv  = dlv;
		row.rep  = (verb != 8'd0);
		row.verb = verb;
		row.opt  = opt;
		return row;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat,
	// with tvalid still high so that back-to-back beats need no toggle.
	task automatic send_byte(input logic [7:0] b, output result_t p);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		p = decode_rx_byte(b);
		rx_results_q.push_back(p);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int n;
		if ($urandom_range(0, 99) < tx_gap_pct) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
			s_axis_tvalid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// raw_mode is only written once the parser has drained.
	task automatic set_raw_mode(input logic v);
		s_axis_tvalid = 1'b0;
		while (rx_results_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we     = 1'b1;
		cfg_wdata  = v;
		raw_mode_q = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic gen_stream(input int n);
		int         pick;
		int         len;
		logic [7:0] opt;
		stim_q.delete();
		while (stim_q.size() < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				len = $urandom_range(1, 8);
				repeat (len) stim_q.push_back(8'($urandom_range(1, 254)));
			end else if (pick < 45) begin
				if ($urandom_range(0, 1))
					stim_q.push_back(CHR_CR);
				stim_q.push_back(CHR_LF);
			end else if (pick < 65) begin
				case ($urandom_range(0, 4))
					0, 1: opt = OPT_ECHO;
					2, 3: opt = OPT_EOR;
					default: opt = 8'($urandom_range(1, 255));
				endcase
				stim_q.push_back(CMD_IAC);
				if ($urandom_range(0, 15) == 0)
					stim_q.push_back(CHR_NUL);
				stim_q.push_back(8'(CMD_WILL + $urandom_range(0, 3)));
				stim_q.push_back(opt);
			end else if (pick < 72) begin
				stim_q.push_back(CMD_IAC);
				stim_q.push_back(CMD_GA);
			end else if (pick < 78) begin
				stim_q.push_back(CMD_IAC);
				stim_q.push_back(OPT_EOR);
			end else if (pick < 81) begin
				stim_q.push_back(CMD_IAC);
				stim_q.push_back(CMD_IAC);
			end else if (pick < 86) begin
				stim_q.push_back(CMD_IAC);
				stim_q.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 92) begin
				stim_q.push_back(CHR_NUL);
			end else begin
				stim_q.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch(name, 32'(got), 32'(want));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (rx_results_q.size() == 0) begin
				report_mismatch("beat with no byte pending", m_axis_tdata, 32'd0);
			end else begin
				want_r              = rx_results_q.pop_front();
				got_r.data_valid    = m_axis_tdata[0];
				got_r.data_byte     = m_axis_tdata[8:1];
				got_r.deliver       = m_axis_tdata[10:9];
				got_r.send_reply    = m_axis_tdata[11];
				got_r.reply_verb    = m_axis_tdata[19:12];
				got_r.reply_option  = m_axis_tdata[27:20];
				got_r.echo_changed  = m_axis_tdata[28];
				got_r.echo_flag_out = m_axis_tdata[29];
				got_r.eor_flag_out  = m_axis_tdata[30];
				check_field("data_valid", 8'(got_r.data_valid), 8'(want_r.data_valid));
				check_field("data_byte", got_r.data_byte, want_r.data_byte);
				check_field("deliver", 8'(got_r.deliver), 8'(want_r.deliver));
				check_field("send_reply", 8'(got_r.send_reply), 8'(want_r.send_reply));
				check_field("reply_verb", got_r.reply_verb, want_r.reply_verb);
				check_field("reply_option", got_r.reply_option, want_r.reply_option);
				check_field("echo_changed", 8'(got_r.echo_changed),
						8'(want_r.echo_changed));
				check_field("echo_flag_out", 8'(got_r.echo_flag_out),
						8'(want_r.echo_flag_out));
				check_field("eor_flag_out", 8'(got_r.eor_flag_out),
						8'(want_r.eor_flag_out));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("%0t ns watchdog: no beat for %0d cycles", $time, WD_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off whenever the stimulus
	// side asks for one so that the input register fills and tready drops.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_done) begin
				hold_done  = hold_seq;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 3);
			end
			if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	initial begin : main_seq
		result_t p;
		int      raw_plan [PHASES]  = '{0, 1, 1, 0, 1, 0, 0, 1};
		int      gap_plan [PHASES]  = '{20, 0, 40, 10, 0, 60, 25, 5};
		int      stall_plan [PHASES] = '{20, 10, 40, 0, 30, 60, 0, 15};

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Cooked mode from reset, then raw mode.
		dir_rows.push_back(mk_row(ROW_BYTE, 8'hFE,    1, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CHR_CR,   1, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CHR_LF,   1, DLV_LINE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CHR_NUL,  1, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_IAC,  0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_GA,   1, DLV_PROMPT, 8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_IAC,  0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_DO,   0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, OPT_ECHO, 1, DLV_NONE,   CMD_WONT, OPT_ECHO));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_IAC,  0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_WILL, 0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, OPT_EOR,  1, DLV_NONE,   CMD_DO, OPT_EOR));
		// With the EOR flag set, IAC EOR ends a prompt.
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_IAC,  0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, OPT_EOR,  1, DLV_PROMPT, 8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_IAC,  0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_WONT, 0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, OPT_ECHO, 1, DLV_NONE,   CMD_DONT, OPT_ECHO));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_IAC,  0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_WILL, 0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, 8'd200,   1, DLV_NONE,   CMD_DONT, 8'd200));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_IAC,  0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_IAC,  1, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_CFG,  8'd1,     0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CHR_NUL,  1, DLV_FLUSH,  8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CHR_CR,   0, DLV_NONE,   8'd0, 8'd0));
		// A chunk end in the middle of a negotiation keeps the sequence alive.
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_IAC,  0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CHR_NUL,  1, DLV_FLUSH,  8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, CMD_DO,   0, DLV_NONE,   8'd0, 8'd0));
		dir_rows.push_back(mk_row(ROW_BYTE, 8'd7,     1, DLV_NONE,   CMD_WONT, 8'd7));

		tx_gap_pct   = 30;
		rx_stall_pct = 20;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				set_raw_mode(dir_rows[i].val[0]);
			end else begin
				send_byte(dir_rows[i].val, p);
				if (dir_rows[i].chk && (p.deliver !== dir_rows[i].dlv
						|| p.send_reply !== dir_rows[i].rep
						|| p.reply_verb !== dir_rows[i].verb
						|| p.reply_option !== dir_rows[i].opt))
					report_mismatch($sformatf("directed row %0d", i),
							32'({p.deliver, p.send_reply, p.reply_verb,
							p.reply_option}),
							32'({dir_rows[i].dlv, dir_rows[i].rep, dir_rows[i].verb,
							dir_rows[i].opt}));
				sender_gap();
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			set_raw_mode(raw_plan[ph][0]);
			tx_gap_pct   = gap_plan[ph];
			rx_stall_pct = stall_plan[ph];
			gen_stream(PHASE_BYTES);
			// Phases without sender gaps also get a long receiver hold-off.
			if (gap_plan[ph] == 0)
				hold_seq++;
			foreach (stim_q[i]) begin
				send_byte(stim_q[i], p);
				sender_gap();
			end
			s_axis_tvalid = 1'b0;
		end

		while (rx_results_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tsp_pkg.sv
rtl/tsp_decode.sv
rtl/telnet_stream_parser.sv
tb/sv/tb_telnet_stream_parser.sv
